FILE: sv/swgq_pkg.sv
// shared types, codes and constants for the score window group queue
package swgq_pkg;

   localparam int DEF_CAPACITY = 32;

   // operation codes carried by the kind field
   localparam logic [2:0] KIND_APPEND = 3'd0;
   localparam logic [2:0] KIND_REMOVE = 3'd1;
   localparam logic [2:0] KIND_SORT   = 3'd2;
   localparam logic [2:0] KIND_GROUP  = 3'd3;
   localparam logic [2:0] KIND_LIST   = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_NOT_FND  = 3'd2;
   localparam logic [2:0] ST_NO_GROUP = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] score;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {A_I, A_JM1, A_JOFF, A_IJ} asel_type;
   typedef enum logic [1:0] {I_HOLD, I_CLR, I_ONE, I_INC} iop_type;
   typedef enum logic [2:0] {J_HOLD, J_CLR, J_LDI, J_INC, J_DEC} jop_type;
   typedef enum logic [1:0] {W_REQ, W_RDA, W_KEY} wsel_type;
   typedef enum logic [1:0] {O_HOLD, O_INC, O_SUB} oop_type;
   typedef enum logic [1:0] {C_ZERO, C_GSZ, C_OCC} csel_type;

   typedef struct packed {
      logic       cap_req;
      asel_type   a_sel;
      logic       wr_en;
      wsel_type   w_sel;
      iop_type    i_op;
      jop_type    j_op;
      logic       key_load;
      oop_type    occ_op;
      logic       emit;
      logic [2:0] st;
      logic       emit_entry;
      csel_type   cnt_sel;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       full;
      logic       occ_zero;
      logic       i_lt_occ;
      logic       win_ok;
      logic       gsz_bad;
      logic       id_match;
      logic       spread_ok;
      logic       after;
      logic       j_zero;
      logic       grp_last;
      logic       lst_last;
      logic       sh_more;
   } stat_type;

endpackage

FILE: sv/score_window_group_queue.sv
// top level of the score window group queue: controller plus datapath
// append writes the entry unless full and returns one status word; remove searches entry by entry,
// then shifts the entries after a match; list emits one word per entry; form group tries windows,
// then emits its words and closes the gap; sort is an insertion sort through the single write port,
// built from compares and moves; one operation is in flight at a time (busy high)
// results leave a register in the cycle after the controller issues them; the receiver cannot stall
// reset clears occupancy and the controller; entry memory contents are undefined until written
module score_window_group_queue #(
   parameter int CAPACITY = swgq_pkg::DEF_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_player_id,
   input  logic [15:0] req_player_score,
   input  logic [31:0] req_player_time,
   input  logic [5:0]  req_group_size,
   input  logic [15:0] req_score_delta,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [15:0] rsp_out_score,
   output logic [31:0] rsp_out_time,
   output logic [5:0]  rsp_count,
   output logic        rsp_last
);
   import swgq_pkg::*;

   // command and status words between controller and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: one state per memory access step
   swgq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // memory, pointers, compare logic and result registers
   swgq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_player_id    (req_player_id),
      .req_player_score (req_player_score),
      .req_player_time  (req_player_time),
      .req_group_size   (req_group_size),
      .req_score_delta  (req_score_delta),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_score    (rsp_out_score),
      .rsp_out_time     (rsp_out_time),
      .rsp_count        (rsp_count),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: sv/swgq_dp.sv
// datapath of the score window group queue: entry memory, pointers, result registers
module swgq_dp #(
   parameter int CAPACITY = swgq_pkg::DEF_CAPACITY
) (
   input  logic              clock,
   input  logic              reset,
   input  swgq_pkg::cmd_type cmd,
   output swgq_pkg::stat_type stat,
   input  logic [2:0]        req_kind,
   input  logic [15:0]       req_player_id,
   input  logic [15:0]       req_player_score,
   input  logic [31:0]       req_player_time,
   input  logic [5:0]        req_group_size,
   input  logic [15:0]       req_score_delta,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_out_id,
   output logic [15:0]       rsp_out_score,
   output logic [31:0]       rsp_out_time,
   output logic [5:0]        rsp_count,
   output logic              rsp_last
);
   import swgq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = ((CW > 6) ? CW : 6) + 1;

   entry_type mem [CAPACITY];

   logic [2:0]    kind_ff;
   logic [15:0]   id_ff, score_ff, delta_ff;
   logic [31:0]   time_ff;
   logic [5:0]    gsz_ff;
   logic [CW-1:0] occ_ff, occ_in;
   logic [SW-1:0] i_ff, i_in, j_ff, j_in;
   entry_type     key_ff, rda_ff, rdb_ff;

   logic           rsp_valid_ff, rsp_last_ff;
   logic [2:0]     rsp_status_ff;
   entry_type      rsp_entry_ff;
   logic [5:0]     rsp_count_ff;

   logic [SW-1:0] occ_w, gsz_w, off, addr_a, addr_b, waddr;
   entry_type     wdata;
   logic [16:0]   spread;

   assign occ_w  = SW'(occ_ff);
   assign gsz_w  = SW'(gsz_ff);
   assign off    = (kind_ff == KIND_GROUP) ? gsz_w : SW'(1);
   assign addr_b = i_ff + gsz_w - SW'(1);
   assign spread = {1'b0, rdb_ff.score} - {1'b0, rda_ff.score};

   always_comb begin
      case (cmd.a_sel)
         A_I:     addr_a = i_ff;
         A_JM1:   addr_a = j_ff - SW'(1);
         A_JOFF:  addr_a = j_ff + off;
         A_IJ:    addr_a = i_ff + j_ff;
         default: addr_a = i_ff;
      endcase
   end

   always_comb begin
      case (cmd.w_sel)
         W_REQ: begin
            waddr = occ_w;
            wdata = '{id: id_ff, score: score_ff, stamp: time_ff};
         end
         W_RDA: begin
            waddr = j_ff;
            wdata = rda_ff;
         end
         W_KEY: begin
            waddr = j_ff;
            wdata = key_ff;
         end
         default: begin
            waddr = j_ff;
            wdata = rda_ff;
         end
      endcase
   end

   always_comb begin
      case (cmd.i_op)
         I_CLR:   i_in = '0;
         I_ONE:   i_in = SW'(1);
         I_INC:   i_in = i_ff + SW'(1);
         default: i_in = i_ff;
      endcase
      case (cmd.j_op)
         J_CLR:   j_in = '0;
         J_LDI:   j_in = i_ff;
         J_INC:   j_in = j_ff + SW'(1);
         J_DEC:   j_in = j_ff - SW'(1);
         default: j_in = j_ff;
      endcase
      case (cmd.occ_op)
         O_INC:   occ_in = occ_ff + CW'(1);
         O_SUB:   occ_in = CW'(occ_w - off);
         default: occ_in = occ_ff;
      endcase
   end

   // status back to the controller
   always_comb begin
      stat.kind      = kind_ff;
      stat.full      = (occ_w == SW'(CAPACITY));
      stat.occ_zero  = (occ_ff == '0);
      stat.i_lt_occ  = (i_ff < occ_w);
      stat.win_ok    = ((i_ff + gsz_w) <= occ_w);
      stat.gsz_bad   = (gsz_ff == '0) || (gsz_w > occ_w);
      stat.id_match  = (rda_ff.id == id_ff);
      stat.spread_ok = ($signed(spread) <= $signed({1'b0, delta_ff}));
      stat.after     = (rda_ff.score != key_ff.score) ? (rda_ff.score > key_ff.score)
                                                      : (rda_ff.stamp > key_ff.stamp);
      stat.j_zero    = (j_ff == '0);
      stat.grp_last  = ((j_ff + SW'(1)) == gsz_w);
      stat.lst_last  = ((i_ff + SW'(1)) == occ_w);
      stat.sh_more   = ((j_ff + off) < occ_w);
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[waddr[IW-1:0]] <= wdata;
      end
      rda_ff <= mem[addr_a[IW-1:0]];
      rdb_ff <= mem[addr_b[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_req) begin
         kind_ff  <= req_kind;
         id_ff    <= req_player_id;
         score_ff <= req_player_score;
         time_ff  <= req_player_time;
         gsz_ff   <= req_group_size;
         delta_ff <= req_score_delta;
      end
      if (cmd.key_load) begin
         key_ff <= rda_ff;
      end
      i_ff <= i_in;
      j_ff <= j_in;
      rsp_status_ff <= cmd.st;
      rsp_entry_ff  <= cmd.emit_entry ? rda_ff : '0;
      rsp_last_ff   <= cmd.last;
      case (cmd.cnt_sel)
         C_GSZ:   rsp_count_ff <= gsz_ff;
         C_OCC:   rsp_count_ff <= occ_w[5:0];
         default: rsp_count_ff <= '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_id    = rsp_entry_ff.id;
   assign rsp_out_score = rsp_entry_ff.score;
   assign rsp_out_time  = rsp_entry_ff.stamp;
   assign rsp_count     = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_w <= SW'(CAPACITY))
      else $error("occupancy above capacity");

   a_wr_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> (waddr < SW'(CAPACITY)))
      else $error("write beyond capacity");

   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_last_ff && rsp_count_ff == '0))
      else $error("failure result not a single final word");

endmodule

FILE: sv/swgq_ctrl.sv
// controller state machine of the score window group queue
module swgq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  swgq_pkg::stat_type stat,
   output swgq_pkg::cmd_type  cmd
);
   import swgq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH,
      S_RM_RD, S_RM_CMP,
      S_SH_RD, S_SH_WR,
      S_SO_NEXT, S_SO_KEY, S_SO_CHK, S_SO_CMP, S_SO_PUT,
      S_GR_RD, S_GR_CMP, S_GR_ERD, S_GR_EMIT,
      S_LS_RD, S_LS_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.cap_req = start;
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            case (stat.kind)
               KIND_APPEND: begin
                  cmd.emit = 1'b1;
                  cmd.last = 1'b1;
                  if (stat.full) begin
                     cmd.st = ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.w_sel  = W_REQ;
                     cmd.occ_op = O_INC;
                     cmd.st     = ST_OK;
                  end
               end
               KIND_REMOVE: begin
                  cmd.i_op = I_CLR;
                  state_in = S_RM_RD;
               end
               KIND_SORT: begin
                  cmd.i_op = I_ONE;
                  state_in = S_SO_NEXT;
               end
               KIND_GROUP: begin
                  if (stat.gsz_bad) begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                     cmd.st   = ST_NO_GROUP;
                  end else begin
                     cmd.i_op = I_CLR;
                     state_in = S_GR_RD;
                  end
               end
               KIND_LIST: begin
                  if (stat.occ_zero) begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                     cmd.st   = ST_EMPTY;
                  end else begin
                     cmd.i_op = I_CLR;
                     state_in = S_LS_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         // remove: linear search for the id
         S_RM_RD: begin
            if (stat.i_lt_occ) begin
               cmd.a_sel = A_I;
               state_in  = S_RM_CMP;
            end else begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.st   = ST_NOT_FND;
               state_in = S_IDLE;
            end
         end
         S_RM_CMP: begin
            if (stat.id_match) begin
               cmd.j_op = J_LDI;
               state_in = S_SH_RD;
            end else begin
               cmd.i_op = I_INC;
               state_in = S_RM_RD;
            end
         end
         // close the gap left by remove or group
         S_SH_RD: begin
            if (stat.sh_more) begin
               cmd.a_sel = A_JOFF;
               state_in  = S_SH_WR;
            end else begin
               cmd.occ_op = O_SUB;
               state_in   = S_IDLE;
               if (stat.kind == KIND_REMOVE) begin
                  cmd.emit = 1'b1;
                  cmd.last = 1'b1;
                  cmd.st   = ST_OK;
               end
            end
         end
         S_SH_WR: begin
            cmd.wr_en = 1'b1;
            cmd.w_sel = W_RDA;
            cmd.j_op  = J_INC;
            state_in  = S_SH_RD;
         end
         // insertion sort
         S_SO_NEXT: begin
            if (stat.i_lt_occ) begin
               cmd.a_sel = A_I;
               state_in  = S_SO_KEY;
            end else begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.st   = ST_OK;
               state_in = S_IDLE;
            end
         end
         S_SO_KEY: begin
            cmd.key_load = 1'b1;
            cmd.j_op     = J_LDI;
            state_in     = S_SO_CHK;
         end
         S_SO_CHK: begin
            if (stat.j_zero) begin
               state_in = S_SO_PUT;
            end else begin
               cmd.a_sel = A_JM1;
               state_in  = S_SO_CMP;
            end
         end
         S_SO_CMP: begin
            if (stat.after) begin
               cmd.wr_en = 1'b1;
               cmd.w_sel = W_RDA;
               cmd.j_op  = J_DEC;
               state_in  = S_SO_CHK;
            end else begin
               state_in = S_SO_PUT;
            end
         end
         S_SO_PUT: begin
            cmd.wr_en = 1'b1;
            cmd.w_sel = W_KEY;
            cmd.i_op  = I_INC;
            state_in  = S_SO_NEXT;
         end
         // group: window scan, then emit and close the gap
         S_GR_RD: begin
            if (stat.win_ok) begin
               cmd.a_sel = A_I;
               state_in  = S_GR_CMP;
            end else begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.st   = ST_NO_GROUP;
               state_in = S_IDLE;
            end
         end
         S_GR_CMP: begin
            if (stat.spread_ok) begin
               cmd.j_op = J_CLR;
               state_in = S_GR_ERD;
            end else begin
               cmd.i_op = I_INC;
               state_in = S_GR_RD;
            end
         end
         S_GR_ERD: begin
            cmd.a_sel = A_IJ;
            state_in  = S_GR_EMIT;
         end
         S_GR_EMIT: begin
            cmd.emit       = 1'b1;
            cmd.st         = ST_OK;
            cmd.emit_entry = 1'b1;
            cmd.cnt_sel    = C_GSZ;
            cmd.last       = stat.grp_last;
            if (stat.grp_last) begin
               cmd.j_op = J_LDI;
               state_in = S_SH_RD;
            end else begin
               cmd.j_op = J_INC;
               state_in = S_GR_ERD;
            end
         end
         // list
         S_LS_RD: begin
            cmd.a_sel = A_I;
            state_in  = S_LS_EMIT;
         end
         S_LS_EMIT: begin
            cmd.emit       = 1'b1;
            cmd.st         = ST_OK;
            cmd.emit_entry = 1'b1;
            cmd.cnt_sel    = C_OCC;
            cmd.last       = stat.lst_last;
            cmd.i_op       = I_INC;
            state_in       = stat.lst_last ? S_IDLE : S_LS_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_cap_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.cap_req |-> (state_ff == S_IDLE))
      else $error("request captured while busy");

   a_emit_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last && stat.kind != KIND_GROUP) |=> (state_ff == S_IDLE))
      else $error("final word without return to idle");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

endmodule

FILE: tb/sv/score_window_group_queue_tb.sv
// testbench for the score window group queue: directed and random command words
module score_window_group_queue_tb;
   import swgq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = DEF_CAPACITY;

   // one expected result word
   typedef struct {
      logic [2:0]  status;
      logic [15:0] id;
      logic [15:0] score;
      logic [31:0] stamp;
      logic [5:0]  count;
      logic        last;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = KIND_APPEND;
   logic [15:0] req_player_id = '0;
   logic [15:0] req_player_score = '0;
   logic [31:0] req_player_time = '0;
   logic [5:0]  req_group_size = '0;
   logic [15:0] req_score_delta = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_out_id;
   logic [15:0] rsp_out_score;
   logic [31:0] rsp_out_time;
   logic [5:0]  rsp_count;
   logic        rsp_last;

   // shadow copy of the list held by the block
   entry_type    shadow_list[CAP];
   int           shadow_occ = 0;
   rsp_word_type pending_rsp[$];
   int           fail_count = 0;
   bit           quiet_phase = 1'b0;

   score_window_group_queue dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // generous bound on the run time of the whole test
   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end

   function automatic void push_status(logic [2:0] st);
      rsp_word_type w;
      w = '{st, 16'd0, 16'd0, 32'd0, 6'd0, 1'b1};
      pending_rsp.push_back(w);
   endfunction

   function automatic void push_entry(entry_type e, int cnt, bit lst);
      rsp_word_type w;
      w = '{ST_OK, e.id, e.score, e.stamp, 6'(cnt), lst};
      pending_rsp.push_back(w);
   endfunction

   // predicts the words caused by one command and updates the shadow list
   function automatic void predict_queue_op(logic [2:0] kind, logic [15:0] pid,
                                            logic [15:0] psc, logic [31:0] ptm,
                                            logic [5:0] gsz, logic [15:0] dlt);
      entry_type key;
      int        j;
      int        spread;
      case (kind)
         KIND_APPEND: begin
            if (shadow_occ >= CAP) begin
               push_status(ST_FULL);
            end else begin
               shadow_list[shadow_occ] = '{pid, psc, ptm};
               shadow_occ++;
               push_status(ST_OK);
            end
         end
         KIND_REMOVE: begin
            for (int i = 0; i < shadow_occ; i++) begin
               if (shadow_list[i].id == pid) begin
                  for (int k = i; k + 1 < shadow_occ; k++) shadow_list[k] = shadow_list[k+1];
                  shadow_occ--;
                  push_status(ST_OK);
                  return;
               end
            end
            push_status(ST_NOT_FND);
         end
         KIND_SORT: begin
            // stable insertion sort, score then earlier stamp
            for (int i = 1; i < shadow_occ; i++) begin
               key = shadow_list[i];
               j = i;
               while (j > 0 && (shadow_list[j-1].score > key.score ||
                      (shadow_list[j-1].score == key.score &&
                       shadow_list[j-1].stamp > key.stamp))) begin
                  shadow_list[j] = shadow_list[j-1];
                  j--;
               end
               shadow_list[j] = key;
            end
            push_status(ST_OK);
         end
         KIND_GROUP: begin
            if (gsz != 0 && int'(gsz) <= shadow_occ) begin
               for (int i = 0; i + gsz <= shadow_occ; i++) begin
                  // signed spread, a negative one always fits
                  spread = int'(shadow_list[i+gsz-1].score) - int'(shadow_list[i].score);
                  if (spread <= int'(dlt)) begin
                     for (int k = 0; k < gsz; k++)
                        push_entry(shadow_list[i+k], gsz, k + 1 == gsz);
                     for (int k = i; k + gsz < shadow_occ; k++)
                        shadow_list[k] = shadow_list[k+gsz];
                     shadow_occ -= gsz;
                     return;
                  end
               end
            end
            push_status(ST_NO_GROUP);
         end
         KIND_LIST: begin
            if (shadow_occ == 0) push_status(ST_EMPTY);
            else
               for (int i = 0; i < shadow_occ; i++)
                  push_entry(shadow_list[i], shadow_occ, i + 1 == shadow_occ);
         end
         default: ;  // unused codes do nothing
      endcase
   endfunction

   // sends one command word, with a random idle gap unless in the quiet phase
   task automatic send_word(logic [2:0] kind, logic [15:0] pid, logic [15:0] psc,
                            logic [31:0] ptm, logic [5:0] gsz, logic [15:0] dlt);
      // the block raises busy after an accept, so no time is lost
      @(negedge clock);
      while (!quiet_phase && $urandom_range(99) < 37) @(negedge clock);
      req_kind         <= kind;
      req_player_id    <= pid;
      req_player_score <= psc;
      req_player_time  <= ptm;
      req_group_size   <= gsz;
      req_score_delta  <= dlt;
      start            <= 1'b1;
      // accepted at the rising edge where busy is low
      do @(posedge clock); while (busy);
      predict_queue_op(kind, pid, psc, ptm, gsz, dlt);
      @(negedge clock);
      start <= 1'b0;
   endtask

   // checks each result word against the oldest prediction
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result word, status %0d", rsp_status);
            fail_count++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_status !== w.status) begin
               $error("status exp %0d got %0d", w.status, rsp_status); fail_count++;
            end
            if (rsp_out_id !== w.id) begin
               $error("out_id exp %0h got %0h", w.id, rsp_out_id); fail_count++;
            end
            if (rsp_out_score !== w.score) begin
               $error("out_score exp %0h got %0h", w.score, rsp_out_score); fail_count++;
            end
            if (rsp_out_time !== w.stamp) begin
               $error("out_time exp %0h got %0h", w.stamp, rsp_out_time); fail_count++;
            end
            if (rsp_count !== w.count) begin
               $error("count exp %0d got %0d", w.count, rsp_count); fail_count++;
            end
            if (rsp_last !== w.last) begin
               $error("last exp %0d got %0d", w.last, rsp_last); fail_count++;
            end
         end
      end
   end

   task automatic do_append(logic [15:0] pid, logic [15:0] psc, logic [31:0] ptm);
      send_word(KIND_APPEND, pid, psc, ptm, 6'd0, 16'd0);
   endtask

   // empty list corner cases, then field extremes and every operation
   task automatic test_directed();
      send_word(KIND_LIST, '0, '0, '0, '0, '0);
      send_word(KIND_REMOVE, 16'hffff, '0, '0, '0, '0);
      send_word(KIND_GROUP, '0, '0, '0, 6'd1, 16'hffff);
      send_word(KIND_SORT, '0, '0, '0, '0, '0);
      do_append(16'h0000, 16'hffff, 32'hffff_ffff);
      do_append(16'hffff, 16'h0000, 32'h0000_0000);
      do_append(16'h1234, 16'h0000, 32'h0000_0001);  // score tie, later stamp
      do_append(16'h1234, 16'h8000, 32'h8000_0000);  // duplicate id
      // unsorted window: negative spread fits a zero delta
      send_word(KIND_GROUP, '0, '0, '0, 6'd2, 16'd0);
      send_word(KIND_GROUP, '0, '0, '0, 6'd0, 16'hffff);   // size zero
      send_word(KIND_GROUP, '0, '0, '0, 6'd63, 16'hffff);  // size above occupancy
      send_word(3'd5, '1, '1, '1, '1, '1);                 // unused codes
      send_word(3'd6, '0, '0, '0, '0, '0);
      send_word(3'd7, '1, '1, '1, '1, '1);
      send_word(KIND_SORT, '0, '0, '0, '0, '0);
      send_word(KIND_LIST, '0, '0, '0, '0, '0);
      send_word(KIND_REMOVE, 16'h1234, '0, '0, '0, '0);    // first match only
      send_word(KIND_REMOVE, 16'h4321, '0, '0, '0, '0);
      send_word(KIND_LIST, '0, '0, '0, '0, '0);
   endtask

   // fill to capacity, refuse one, full list and a whole-list group
   task automatic test_full();
      while (shadow_occ < CAP) do_append(16'($urandom), 16'($urandom_range(255)), $urandom);
      do_append(16'hbeef, 16'h1, 32'h2);
      send_word(KIND_SORT, '0, '0, '0, '0, '0);
      send_word(KIND_LIST, '0, '0, '0, '0, '0);
      send_word(KIND_GROUP, '0, '0, '0, 6'(CAP), 16'hffff);
   endtask

   // mostly sensible sequences: small ids and scores so removes and groups hit
   task automatic test_random(int n_words);
      int sel;
      for (int n = 0; n < n_words; n++) begin
         quiet_phase = (n >= 100 && n < 160);
         sel = $urandom_range(99);
         if (sel < 40)
            do_append(($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40)),
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(100)),
                      $urandom);
         else if (sel < 55)
            send_word(KIND_REMOVE, ($urandom_range(4) == 0) ? 16'($urandom)
                      : 16'($urandom_range(40)), 16'($urandom), $urandom, 6'($urandom), 16'($urandom));
         else if (sel < 65)
            send_word(KIND_SORT, 16'($urandom), 16'($urandom), $urandom, 6'($urandom), 16'($urandom));
         else if (sel < 85)
            send_word(KIND_GROUP, 16'($urandom), 16'($urandom), $urandom,
                      ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(5)),
                      ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30)));
         else if (sel < 95)
            send_word(KIND_LIST, 16'($urandom), 16'($urandom), $urandom, 6'($urandom), 16'($urandom));
         else
            send_word(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom), $urandom,
                      6'($urandom), 16'($urandom));
      end
      quiet_phase = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full();
      test_random(330);
      // drain, then let a trailing operation settle
      fork
         wait (pending_rsp.size() == 0);
         begin
            repeat (200000) @(posedge clock);
            $error("timeout waiting for result words");
            fail_count++;
         end
      join_any
      disable fork;
      repeat (3000) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: score_window_group_queue.f
sv/swgq_pkg.sv
sv/swgq_dp.sv
sv/swgq_ctrl.sv
sv/score_window_group_queue.sv
tb/sv/score_window_group_queue_tb.sv
